### hw/rtl/nfpa_pkg.sv
// Shared types and constants of the next-fit page allocator.
// No dependencies; used by every module of the allocator.
package nfpa_pkg;

    // Pages held in one bitmap memory word.
    localparam int WORD_PAGES = 64;
    localparam int BIT_W      = 6;
    // Page numbers and bounds run up to 65536, so they need 17 bits.
    localparam int CNT_W      = 17;
    localparam int PAGE_W     = 16;
    localparam int WIDX_W     = CNT_W - BIT_W;

    // Operation codes carried in the input stream's tuser.
    localparam logic [1:0] OP_ALLOC      = 2'd0;
    localparam logic [1:0] OP_FREE       = 2'd1;
    localparam logic [1:0] OP_SET_USABLE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_NUM_PAGES    = 1'b0;
    localparam logic CFG_SEARCH_START = 1'b1;

    // One memory word: allocated and usable bits of 64 consecutive pages.
    typedef struct packed {
        logic [WORD_PAGES-1:0] alloc;
        logic [WORD_PAGES-1:0] usable;
    } t_bm_word;

endpackage

### hw/rtl/next_fit_page_allocator_unit.sv
// Next-fit page allocator: control sequencer, bitmap memory and word picker.
// Depends on nfpa_pkg, nfpa_bitmap_ram and nfpa_word_pick.
//
// Usage: operations arrive on the s-stream (op in tuser, page and usable
// flag in tdata), one result per operation leaves on the m-stream
// (granted_page in tdata, granted in tuser). Configuration registers
// num_pages and search_start are written through i_cfg_we/addr/wdata.
// Bitmaps are held 64 pages per word in one memory with a registered read.
// Free and set-usable go from transfer to result through a read, a
// modify-write and the output load. Allocate reads one word per cycle
// from the next-fit pointer to the bound, then from search_start up to
// the pointer, so on a wrap the pointer's word may be read twice; the
// memory read port sets that rate. One operation is in progress
// at a time.
// After reset the bitmap is cleared one word per cycle, every word of
// the memory, before the first input transfer.
// The result sits in an output register; while the receiver stalls, the
// next operation can be taken and worked on, and waits only to deliver.
module next_fit_page_allocator_unit #(
    parameter int MAX_PAGES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Operation stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] page_index, [16] usable, [23:17] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] granted_page
    output logic        o_m_tuser,   // [0] granted
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [16:0] i_cfg_wdata
);

    localparam int CW        = nfpa_pkg::CNT_W;
    localparam int BW        = nfpa_pkg::BIT_W;
    localparam int WW        = nfpa_pkg::WIDX_W;
    localparam int PW        = nfpa_pkg::PAGE_W;
    localparam int WP        = nfpa_pkg::WORD_PAGES;
    localparam int USE_PAGES = (MAX_PAGES < 65536) ? MAX_PAGES : 65536;
    localparam int WORDS     = (USE_PAGES + WP - 1) / WP;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [CW-1:0] PAGE_LIM = CW'(USE_PAGES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_MOD,
        S_PUT
    } t_state;

    // Control registers.
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_num_pages, n_num_pages;
    logic [PW-1:0]      r_search_start, n_search_start;
    logic               r_phase, n_phase;
    logic               r_iss_done, n_iss_done;
    logic               r_chk_vld, n_chk_vld;
    logic               r_m_valid, n_m_valid;
    // Payload registers.
    logic [1:0]         r_op, n_op;
    logic [PW-1:0]      r_page, n_page;
    logic               r_use, n_use;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [WW-1:0]      r_iss_word, n_iss_word;
    logic [WW-1:0]      r_chk_word, n_chk_word;
    logic [WW-1:0]      r_last, n_last;
    logic [PW-1:0]      r_res_page, n_res_page;
    logic               r_res_ok, n_res_ok;
    logic [PW-1:0]      r_m_page, n_m_page;
    logic               r_m_ok, n_m_ok;

    // Memory and picker connections.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    nfpa_pkg::t_bm_word mem_wdata;
    logic [AW-1:0]      mem_raddr;
    nfpa_pkg::t_bm_word mem_rdata;
    logic               pick_hit;
    logic [BW-1:0]      pick_bit;

    logic [CW-1:0]      bound;
    logic [CW-1:0]      hi_m1;
    logic [WW-1:0]      in_word;
    logic [WW-1:0]      page_word;
    logic [CW-1:0]      hit_page;
    logic [WP-1:0]      page_bit;
    logic [WP-1:0]      hit_bit;

    nfpa_bitmap_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    nfpa_word_pick u_pick (
        .i_word     (mem_rdata),
        .i_word_idx (r_chk_word),
        .i_lo       (r_lo),
        .i_hi       (r_hi),
        .o_hit      (pick_hit),
        .o_bit      (pick_bit)
    );

    // Pages in use stop at the smaller of num_pages and the memory size.
    assign bound     = (r_num_pages < PAGE_LIM) ? r_num_pages : PAGE_LIM;
    assign hi_m1     = r_hi - CW'(1);
    assign in_word   = WW'(i_s_tdata[PW-1:BW]);
    assign page_word = WW'(r_page[PW-1:BW]);
    assign hit_page  = {r_chk_word, pick_bit};
    assign page_bit  = WP'(1) << r_page[BW-1:0];
    assign hit_bit   = WP'(1) << pick_bit;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_ptr          = r_ptr;
        n_num_pages    = r_num_pages;
        n_search_start = r_search_start;
        n_phase        = r_phase;
        n_iss_done     = r_iss_done;
        n_chk_vld      = r_chk_vld;
        n_m_valid      = r_m_valid & ~i_m_tready;
        n_op           = r_op;
        n_page         = r_page;
        n_use          = r_use;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_iss_word     = r_iss_word;
        n_chk_word     = r_chk_word;
        n_last         = r_last;
        n_res_page     = r_res_page;
        n_res_ok       = r_res_ok;
        n_m_page       = r_m_page;
        n_m_ok         = r_m_ok;
        mem_we         = 1'b0;
        mem_waddr      = r_clr_addr;
        mem_wdata      = '0;
        mem_raddr      = r_iss_word[AW-1:0];

        // Configuration writes.
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                nfpa_pkg::CFG_NUM_PAGES:    n_num_pages    = i_cfg_wdata;
                nfpa_pkg::CFG_SEARCH_START: n_search_start = i_cfg_wdata[PW-1:0];
                default:                    n_num_pages    = r_num_pages;
            endcase
        end

        unique case (r_state)
            // Zero the bitmap one word per cycle after reset.
            S_CLEAR: begin
                mem_we     = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take an operation; start the word read for free and set-usable.
            S_IDLE: begin
                mem_raddr = in_word[AW-1:0];
                if (i_s_tvalid) begin
                    n_op   = i_s_tuser;
                    n_page = i_s_tdata[PW-1:0];
                    n_use  = i_s_tdata[PW];
                    if (i_s_tuser == nfpa_pkg::OP_ALLOC) begin
                        n_lo    = r_ptr;
                        n_hi    = bound;
                        n_phase = 1'b0;
                        n_state = S_INIT;
                    end else if ((i_s_tuser == nfpa_pkg::OP_FREE ||
                                  i_s_tuser == nfpa_pkg::OP_SET_USABLE) &&
                                 ({1'b0, i_s_tdata[PW-1:0]} < bound)) begin
                        n_state = S_MOD;
                    end else begin
                        n_res_page = '0;
                        n_res_ok   = 1'b0;
                        n_state    = S_PUT;
                    end
                end
            end

            // Set up one scan range, or move on when it is empty.
            S_INIT: begin
                if (r_lo < r_hi) begin
                    n_iss_word = r_lo[CW-1:BW];
                    n_last     = hi_m1[CW-1:BW];
                    n_iss_done = 1'b0;
                    n_chk_vld  = 1'b0;
                    n_state    = S_SCAN;
                end else if (!r_phase) begin
                    n_phase = 1'b1;
                    n_lo    = {1'b0, r_search_start};
                    n_hi    = (r_ptr < bound) ? r_ptr : bound;
                end else begin
                    n_res_page = '0;
                    n_res_ok   = 1'b0;
                    n_state    = S_PUT;
                end
            end

            // Issue one word read per cycle and check the word that returns.
            S_SCAN: begin
                n_chk_vld  = ~r_iss_done;
                n_chk_word = r_iss_word;
                if (!r_iss_done) begin
                    n_iss_word = r_iss_word + WW'(1);
                    n_iss_done = (r_iss_word == r_last);
                end
                if (r_chk_vld) begin
                    if (pick_hit) begin
                        mem_we          = 1'b1;
                        mem_waddr       = r_chk_word[AW-1:0];
                        mem_wdata       = mem_rdata;
                        mem_wdata.alloc = mem_rdata.alloc | hit_bit;
                        n_ptr           = hit_page + CW'(1);
                        n_res_page      = hit_page[PW-1:0];
                        n_res_ok        = 1'b1;
                        n_state         = S_PUT;
                    end else if (r_chk_word == r_last) begin
                        if (!r_phase) begin
                            n_phase = 1'b1;
                            n_lo    = {1'b0, r_search_start};
                            n_hi    = (r_ptr < bound) ? r_ptr : bound;
                            n_state = S_INIT;
                        end else begin
                            n_res_page = '0;
                            n_res_ok   = 1'b0;
                            n_state    = S_PUT;
                        end
                    end
                end
            end

            // Modify the word read in the idle cycle and write it back.
            S_MOD: begin
                mem_we    = 1'b1;
                mem_waddr = page_word[AW-1:0];
                mem_wdata = mem_rdata;
                if (r_op == nfpa_pkg::OP_FREE) begin
                    mem_wdata.alloc = mem_rdata.alloc & ~page_bit;
                    if ({1'b0, r_page} < r_ptr) begin
                        n_ptr = {1'b0, r_page};
                    end
                end else if (r_use) begin
                    mem_wdata.usable = mem_rdata.usable | page_bit;
                end else begin
                    mem_wdata.usable = mem_rdata.usable & ~page_bit;
                end
                n_res_page = '0;
                n_res_ok   = 1'b1;
                n_state    = S_PUT;
            end

            // Load the output register once it is free or being drained.
            S_PUT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_page  = r_res_page;
                    n_m_ok    = r_res_ok;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_ptr          <= '0;
            r_num_pages    <= CW'(65536);
            r_search_start <= '0;
            r_phase        <= 1'b0;
            r_iss_done     <= 1'b0;
            r_chk_vld      <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_ptr          <= n_ptr;
            r_num_pages    <= n_num_pages;
            r_search_start <= n_search_start;
            r_phase        <= n_phase;
            r_iss_done     <= n_iss_done;
            r_chk_vld      <= n_chk_vld;
            r_m_valid      <= n_m_valid;
        end
        r_op       <= n_op;
        r_page     <= n_page;
        r_use      <= n_use;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_iss_word <= n_iss_word;
        r_chk_word <= n_chk_word;
        r_last     <= n_last;
        r_res_page <= n_res_page;
        r_res_ok   <= n_res_ok;
        r_m_page   <= n_m_page;
        r_m_ok     <= n_m_ok;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_page;
    assign o_m_tuser  = r_m_ok;

endmodule

### hw/rtl/nfpa_bitmap_ram.sv
// Bitmap memory of the page allocator: one write port, one read port,
// registered read data. Depends on nfpa_pkg for the word type.
module nfpa_bitmap_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  nfpa_pkg::t_bm_word i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output nfpa_pkg::t_bm_word o_rdata
);

    nfpa_pkg::t_bm_word r_mem [DEPTH];
    nfpa_pkg::t_bm_word r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/nfpa_word_pick.sv
// Finds the lowest usable, unallocated page of one bitmap word inside a
// page range [lo, hi). Depends on nfpa_pkg for widths and the word type.
module nfpa_word_pick (
    input  nfpa_pkg::t_bm_word                 i_word,
    input  logic [nfpa_pkg::WIDX_W-1:0]        i_word_idx,
    input  logic [nfpa_pkg::CNT_W-1:0]         i_lo,
    input  logic [nfpa_pkg::CNT_W-1:0]         i_hi,
    output logic                               o_hit,
    output logic [nfpa_pkg::BIT_W-1:0]         o_bit
);

    localparam int WP = nfpa_pkg::WORD_PAGES;

    logic [nfpa_pkg::CNT_W-1:0] hi_m1;
    logic [WP-1:0]              lo_mask;
    logic [WP-1:0]              hi_mask;
    logic [WP-1:0]              cand;
    logic [WP-1:0]              lowest;

    assign hi_m1 = i_hi - nfpa_pkg::CNT_W'(1);

    // Range masks for the first and last word of the range.
    always_comb begin
        lo_mask = '1;
        hi_mask = '1;
        if (i_word_idx == i_lo[nfpa_pkg::CNT_W-1:nfpa_pkg::BIT_W]) begin
            lo_mask = {WP{1'b1}} << i_lo[nfpa_pkg::BIT_W-1:0];
        end
        if (i_word_idx == hi_m1[nfpa_pkg::CNT_W-1:nfpa_pkg::BIT_W]) begin
            hi_mask = {WP{1'b1}} >> (nfpa_pkg::BIT_W'(WP - 1) - hi_m1[nfpa_pkg::BIT_W-1:0]);
        end
    end

    // Candidates, then isolate the lowest one with a two's complement trick.
    assign cand   = i_word.usable & ~i_word.alloc & lo_mask & hi_mask;
    assign lowest = cand & (~cand + WP'(1));
    assign o_hit  = |cand;

    // Encode the one-hot position; each index bit is an independent OR.
    always_comb begin
        o_bit = '0;
        for (int b = 0; b < nfpa_pkg::BIT_W; b++) begin
            for (int i = 0; i < WP; i++) begin
                if (((i >> b) & 1) == 1) begin
                    o_bit[b] = o_bit[b] | lowest[i];
                end
            end
        end
    end

endmodule
